FILE: rtl/drte_pkg.sv
// drte_pkg: command and status codes and the token control word
// shared by the route table cells, the cell chain and the top level
// no dependencies
package drte_pkg;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SELF = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	localparam int PORT_BITS = 16;

	// control word that walks down the chain with one command
	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic found;
		logic appended;
	} tok_t;

endpackage

FILE: rtl/drte_cell.sv
// drte_cell: one route entry (destination and next hop) and one token stage
// depends on drte_pkg
module drte_cell #(
	parameter int IDX = 0,
	parameter int W   = 16,
	parameter int CW  = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  drte_pkg::tok_t  tok,
	input  logic [W-1:0]    addr,
	input  logic [W-1:0]    hop,
	input  logic [CW-1:0]   count,
	input  logic [W-1:0]    nbr_dest,
	input  logic [W-1:0]    nbr_hop,
	output drte_pkg::tok_t  pass_tok,
	output logic [W-1:0]    pass_addr,
	output logic [W-1:0]    pass_hop,
	output logic [W-1:0]    dest,
	output logic [W-1:0]    entry_hop
);
	import drte_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [W-1:0] dest_q;
	logic [W-1:0] ehop_q;
	tok_t         tok_q;
	logic [W-1:0] addr_q;
	logic [W-1:0] thop_q;

	logic         live;
	logic         match;
	tok_t         tok_d;
	logic [W-1:0] thop_d;
	logic         wr_en;
	logic [W-1:0] wr_dest;
	logic [W-1:0] wr_hop;

	assign live  = IDX_C < count;
	assign match = tok.valid && live && (dest_q == addr);

	always_comb begin
		tok_d   = tok;
		thop_d  = hop;
		wr_en   = 1'b0;
		wr_dest = dest_q;
		wr_hop  = ehop_q;
		if (tok.valid) begin
			unique case (tok.cmd)
				CMD_SET: begin
					if (match) begin
						// existing route: new next hop
						wr_en       = 1'b1;
						wr_hop      = hop;
						tok_d.found = 1'b1;
					end else if (!tok.found && !tok.appended && IDX_C == count) begin
						// first free slot: append
						wr_en          = 1'b1;
						wr_dest        = addr;
						wr_hop         = hop;
						tok_d.appended = 1'b1;
					end
				end
				CMD_LOOKUP: begin
					if (match) begin
						thop_d      = ehop_q;
						tok_d.found = 1'b1;
					end
				end
				CMD_DELETE: begin
					// from the match on, every live entry takes its upper neighbor
					if (live && (tok.found || match)) begin
						wr_en       = 1'b1;
						wr_dest     = nbr_dest;
						wr_hop      = nbr_hop;
						tok_d.found = 1'b1;
					end
				end
				CMD_CLEAR: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr;
		thop_q <= thop_d;
		if (wr_en) begin
			dest_q <= wr_dest;
			ehop_q <= wr_hop;
		end
	end

	assign pass_tok  = tok_q;
	assign pass_addr = addr_q;
	assign pass_hop  = thop_q;
	assign dest      = dest_q;
	assign entry_hop = ehop_q;

endmodule

FILE: rtl/drte_chain.sv
// drte_chain: row of route cells for one table, token enters at cell zero
// depends on drte_pkg and drte_cell
module drte_chain #(
	parameter int N  = 256,
	parameter int W  = 16,
	parameter int CW = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  drte_pkg::tok_t  tok,
	input  logic [W-1:0]    addr,
	input  logic [W-1:0]    hop,
	input  logic [CW-1:0]   count,
	output drte_pkg::tok_t  last_tok,
	output logic [W-1:0]    last_hop
);
	import drte_pkg::*;

	tok_t         tok_w   [0:N];
	logic [W-1:0] addr_w  [0:N];
	logic [W-1:0] thop_w  [0:N];
	logic [W-1:0] dest_w  [0:N];
	logic [W-1:0] ehop_w  [0:N];

	assign tok_w[0]  = tok;
	assign addr_w[0] = addr;
	assign thop_w[0] = hop;
	// nothing above the top cell
	assign dest_w[N] = '0;
	assign ehop_w[N] = '0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		drte_cell #(
			.IDX (g),
			.W   (W),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok       (tok_w[g]),
			.addr      (addr_w[g]),
			.hop       (thop_w[g]),
			.count     (count),
			.nbr_dest  (dest_w[g+1]),
			.nbr_hop   (ehop_w[g+1]),
			.pass_tok  (tok_w[g+1]),
			.pass_addr (addr_w[g+1]),
			.pass_hop  (thop_w[g+1]),
			.dest      (dest_w[g]),
			.entry_hop (ehop_w[g])
		);
	end

	assign last_tok = tok_w[N];
	assign last_hop = thop_w[N];

endmodule

FILE: rtl/dual_route_table_engine.sv
// dual_route_table_engine: unicast and group exact-match route tables
// timing: set, lookup and delete strobe their result after the token has walked every cell
//   of the chain and passed the result register; clear and self-route answer in the next cycle
// throughput: a set/lookup/delete holds busy until its token has walked down the whole
//   cell chain; clear or self-route every cycle while not busy; results cannot be stalled
// reset: arst_n clears both counts, busy and the strobe; entry contents are left as they are
module dual_route_table_engine #(
	parameter int MAX_ROUTES = 256,
	parameter int ADDR_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic        table_select,
	input  logic [15:0] dest_address,
	input  logic [15:0] new_next_hop,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] found_next_hop
);
	import drte_pkg::*;

	// stored address width: the ports carry 16 bits
	localparam int W  = (ADDR_BITS < PORT_BITS) ? ADDR_BITS : PORT_BITS;
	localparam int CW = $clog2(MAX_ROUTES + 1);

	logic          busy_q;
	logic          done_q;
	status_t       status_q;
	logic [15:0]   fnh_q;
	tok_t          tok_q;
	logic          sel_q;
	logic [W-1:0]  taddr_q;
	logic [W-1:0]  thop_q;
	logic [CW-1:0] ucount_q;
	logic [CW-1:0] gcount_q;

	logic          accept;
	cmd_t          cmd_in;
	logic [W-1:0]  addr_in;
	logic [W-1:0]  hop_in;
	logic          self_route;
	tok_t          utok_in;
	tok_t          gtok_in;
	tok_t          utok_out;
	tok_t          gtok_out;
	logic [W-1:0]  uhop_out;
	logic [W-1:0]  ghop_out;
	tok_t          tok_end;
	logic [W-1:0]  hop_end;
	logic [CW-1:0] count_sel;

	assign accept     = start && !busy_q;
	assign cmd_in     = cmd_t'(command);
	assign addr_in    = dest_address[W-1:0];
	assign hop_in     = new_next_hop[W-1:0];
	assign self_route = addr_in == hop_in;

	// token goes only into the chain of the selected table
	always_comb begin
		utok_in       = tok_q;
		gtok_in       = tok_q;
		utok_in.valid = tok_q.valid && !sel_q;
		gtok_in.valid = tok_q.valid && sel_q;
	end

	drte_chain #(
		.N  (MAX_ROUTES),
		.W  (W),
		.CW (CW)
	) u_uni (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (utok_in),
		.addr     (taddr_q),
		.hop      (thop_q),
		.count    (ucount_q),
		.last_tok (utok_out),
		.last_hop (uhop_out)
	);

	drte_chain #(
		.N  (MAX_ROUTES),
		.W  (W),
		.CW (CW)
	) u_grp (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (gtok_in),
		.addr     (taddr_q),
		.hop      (thop_q),
		.count    (gcount_q),
		.last_tok (gtok_out),
		.last_hop (ghop_out)
	);

	// end of the walk for the table in use
	assign tok_end   = sel_q ? gtok_out : utok_out;
	assign hop_end   = sel_q ? ghop_out : uhop_out;
	assign count_sel = sel_q ? gcount_q : ucount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			tok_q    <= '0;
			sel_q    <= 1'b0;
			ucount_q <= '0;
			gcount_q <= '0;
		end else begin
			done_q      <= 1'b0;
			tok_q.valid <= 1'b0;
			if (accept) begin
				sel_q <= table_select;
				priority if (cmd_in == CMD_CLEAR) begin
					done_q <= 1'b1;
					if (table_select) begin
						gcount_q <= '0;
					end else begin
						ucount_q <= '0;
					end
				end else if (cmd_in == CMD_SET && self_route) begin
					done_q <= 1'b1;
				end else begin
					// walk the chain
					busy_q <= 1'b1;
					tok_q  <= '{valid: 1'b1, cmd: cmd_in, found: 1'b0, appended: 1'b0};
				end
			end else if (tok_end.valid) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (tok_end.cmd == CMD_SET && tok_end.appended) begin
					if (sel_q) begin
						gcount_q <= count_sel + 1'b1;
					end else begin
						ucount_q <= count_sel + 1'b1;
					end
				end else if (tok_end.cmd == CMD_DELETE && tok_end.found) begin
					if (sel_q) begin
						gcount_q <= count_sel - 1'b1;
					end else begin
						ucount_q <= count_sel - 1'b1;
					end
				end
			end
		end
	end

	// result payload and token payload
	always_ff @(posedge clk) begin
		if (accept) begin
			taddr_q  <= addr_in;
			thop_q   <= hop_in;
			fnh_q    <= '0;
			status_q <= (cmd_in == CMD_SET && self_route) ? ST_SELF : ST_OK;
		end else if (tok_end.valid) begin
			fnh_q    <= '0;
			status_q <= ST_OK;
			unique case (tok_end.cmd)
				CMD_SET: begin
					// full only when neither overwritten nor appended
					if (!tok_end.found && !tok_end.appended) begin
						status_q <= ST_FULL;
					end
				end
				CMD_LOOKUP: begin
					if (tok_end.found) begin
						fnh_q <= 16'(hop_end);
					end else begin
						status_q <= ST_NONE;
					end
				end
				CMD_DELETE: begin
					if (!tok_end.found) begin
						status_q <= ST_NONE;
					end
				end
				CMD_CLEAR: begin
				end
			endcase
		end
	end

	assign busy           = busy_q;
	assign done           = done_q;
	assign status         = status_q;
	assign found_next_hop = fnh_q;

endmodule

FILE: rtl/drte_checker.sv
// drte_checker: port-level checks for dual_route_table_engine, bound to the top level
// depends on drte_pkg
module drte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  command,
	input logic        table_select,
	input logic [15:0] dest_address,
	input logic [15:0] new_next_hop,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] found_next_hop
);
	import drte_pkg::*;

	// clear answers ok in the next cycle with no next hop
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_CLEAR |=>
		done && status == ST_OK && found_next_hop == '0)
		else $error("clear did not answer ok at once");

	// route to itself is refused in the next cycle
	a_self: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_SET && dest_address == new_next_hop |=>
		done && status == ST_SELF && !busy)
		else $error("self route not refused");

	// table walks hold busy
	a_walk: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == CMD_LOOKUP || command == CMD_DELETE ||
		(command == CMD_SET && dest_address != new_next_hop)) |=> busy && !done)
		else $error("table walk did not raise busy");

	// no strobe while a walk is still in progress
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && busy))
		else $error("result strobe while busy");

	// only a successful result can carry a next hop
	a_hop: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> found_next_hop == '0)
		else $error("next hop on a failed result");

endmodule

bind dual_route_table_engine drte_checker u_drte_checker (.*);
